// ===== src/vqbd_pkg.sv =====
// Package with the shared types and constants of the vector-quantization block decoder.
package vqbd_pkg;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_INDEX_W-1:0] CFG_CODEBOOK_SIZE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLOCKS_PER_SIDE = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [8:0] CODEBOOK_SIZE_RST = 9'd32;
	localparam logic [6:0] BLOCKS_PER_SIDE_RST = 7'd64;

	// Input item modes.
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// Number of commands the queue between front and back holds.
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic       mode;
		logic [7:0] load_entry;
		logic [5:0] load_element;
		logic [7:0] load_value;
		logic [7:0] code_index;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic [8:0] pixel_row;
		logic [8:0] pixel_col;
		logic       block_end;
		logic       image_end;
		logic       bad_index;
	} out_item_t;

	// One command from the front to the back: a codebook write or a block decode.
	typedef struct packed {
		logic       is_decode;
		logic [7:0] entry;
		logic [7:0] element;
		logic [7:0] value;
		logic       bad;
		logic [8:0] base_row;
		logic [8:0] base_col;
		logic       image_last;
	} cmd_t;

endpackage

// ===== src/vqbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vqbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/vqbd_queue.sv =====
// Short command queue between the front and the back of the decoder.
module vqbd_queue
	import vqbd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/vqbd_front.sv =====
// Front of the decoder: configuration registers, item classification and block position.
module vqbd_front
	import vqbd_pkg::*;
#(
	parameter int CODEBOOK_DEPTH = 32,
	parameter int BLOCK_DIM = 8,
	parameter int MAX_BLOCKS_PER_SIDE = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   push,
	output cmd_t                   push_cmd,
	input  logic                   queue_full
);

	localparam int PIX = BLOCK_DIM * BLOCK_DIM;

	logic [8:0] codebook_size_q;
	logic [6:0] blocks_per_side_q;
	logic [5:0] block_row_q;
	logic [5:0] block_col_q;

	logic       accept;
	logic       load_ok;
	logic [6:0] side;
	logic       last_col;
	logic       last_row;
	logic [9:0] base_row;
	logic [9:0] base_col;

	assign cfg_ready = 1'b1;
	assign in_stall = queue_full;
	assign accept = in_valid && !queue_full;

	// Width 0 acts as one block, widths above the maximum act as the maximum.
	always_comb begin
		if (blocks_per_side_q == '0) begin
			side = 7'd1;
		end else if (blocks_per_side_q > 7'(MAX_BLOCKS_PER_SIDE)) begin
			side = 7'(MAX_BLOCKS_PER_SIDE);
		end else begin
			side = blocks_per_side_q;
		end
	end

	assign last_col = ({1'b0, block_col_q} + 7'd1) >= side;
	assign last_row = ({1'b0, block_row_q} + 7'd1) >= side;
	assign base_row = 10'(block_row_q) * 10'(BLOCK_DIM);
	assign base_col = 10'(block_col_q) * 10'(BLOCK_DIM);

	assign load_ok = ({1'b0, in_data.load_entry} < 9'(CODEBOOK_DEPTH))
		&& ({3'b0, in_data.load_element} < 9'(PIX));

	always_comb begin
		push_cmd.is_decode = (in_data.mode == MODE_DECODE);
		push_cmd.entry = (in_data.mode == MODE_DECODE) ? in_data.code_index : in_data.load_entry;
		push_cmd.element = {2'b0, in_data.load_element};
		push_cmd.value = in_data.load_value;
		push_cmd.bad = !(({1'b0, in_data.code_index} < codebook_size_q)
			&& ({1'b0, in_data.code_index} < 9'(CODEBOOK_DEPTH)));
		push_cmd.base_row = base_row[8:0];
		push_cmd.base_col = base_col[8:0];
		push_cmd.image_last = last_col && last_row;
	end

	// Loads outside the store are dropped here.
	assign push = accept && ((in_data.mode == MODE_DECODE) || load_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codebook_size_q <= CODEBOOK_SIZE_RST;
			blocks_per_side_q <= BLOCKS_PER_SIDE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CODEBOOK_SIZE:   codebook_size_q <= cfg_data;
				CFG_BLOCKS_PER_SIDE: blocks_per_side_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_row_q <= '0;
			block_col_q <= '0;
		end else if (accept && (in_data.mode == MODE_DECODE)) begin
			if (last_col) begin
				block_col_q <= '0;
				block_row_q <= last_row ? '0 : block_row_q + 6'd1;
			end else begin
				block_col_q <= block_col_q + 6'd1;
			end
		end
	end

endmodule

// ===== src/vqbd_back.sv =====
// Back of the decoder: codebook writes and pixel-by-pixel block expansion.
module vqbd_back
	import vqbd_pkg::*;
#(
	parameter int CODEBOOK_DEPTH = 32,
	parameter int BLOCK_DIM = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	input  cmd_t      head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int PIX = BLOCK_DIM * BLOCK_DIM;
	localparam int EL_W = $clog2(PIX);
	localparam int CB_W = $clog2(CODEBOOK_DEPTH);
	localparam int DIM_W = $clog2(BLOCK_DIM);
	localparam int RAM_DEPTH = CODEBOOK_DEPTH * (2 ** EL_W);

	logic [EL_W-1:0]  k_q;
	logic [DIM_W-1:0] r_q;
	logic [DIM_W-1:0] c_q;

	logic       valid_s1;
	logic [8:0] row_s1;
	logic [8:0] col_s1;
	logic       block_end_s1;
	logic       image_end_s1;
	logic       bad_s1;

	logic      out_valid_q;
	out_item_t out_q;

	logic            s2_free;
	logic            adv;
	logic            issue;
	logic            last_k;
	logic            load_pop;
	logic [7:0]      rdata;
	logic [CB_W+EL_W-1:0] raddr;
	logic [CB_W+EL_W-1:0] waddr;

	assign s2_free = !out_valid_q || !out_stall;
	assign adv = !valid_s1 || s2_free;
	assign load_pop = !empty && !head.is_decode;
	assign issue = !empty && head.is_decode && adv;
	assign last_k = (k_q == EL_W'(PIX - 1));
	assign pop = load_pop || (issue && last_k);

	assign raddr = {head.entry[CB_W-1:0], k_q};
	assign waddr = {head.entry[CB_W-1:0], head.element[EL_W-1:0]};

	vqbd_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (load_pop),
		.waddr(waddr),
		.wdata(head.value),
		.re   (issue && !head.bad),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			r_q <= '0;
			c_q <= '0;
		end else if (issue) begin
			if (last_k) begin
				k_q <= '0;
				r_q <= '0;
				c_q <= '0;
			end else begin
				k_q <= k_q + 1'b1;
				if (c_q == DIM_W'(BLOCK_DIM - 1)) begin
					c_q <= '0;
					r_q <= r_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			row_s1 <= head.base_row + 9'(r_q);
			col_s1 <= head.base_col + 9'(c_q);
			block_end_s1 <= last_k;
			image_end_s1 <= last_k && head.image_last;
			bad_s1 <= head.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			out_q.pixel <= bad_s1 ? 8'd0 : rdata;
			out_q.pixel_row <= row_s1;
			out_q.pixel_col <= col_s1;
			out_q.block_end <= block_end_s1;
			out_q.image_end <= image_end_s1;
			out_q.bad_index <= bad_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef NO_ASSERTIONS
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.bad_index |-> out_q.pixel == 8'd0)
		else $error("bad index result carries a nonzero pixel");

	a_image_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.image_end |-> out_q.block_end)
		else $error("image end flagged away from a block end");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(row_s1) && $stable(col_s1))
		else $error("read stage lost its pixel while the output was stalled");

	a_pop_only_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command queue popped while empty");
`endif

endmodule

// ===== src/vq_block_decoder_unit.sv =====
// Top level of the vector-quantization block decoder.
//
// The block decodes a vector-quantized image: load items write one byte of a codeword
// into the codebook store, and each index item expands into the BLOCK_DIM x BLOCK_DIM
// pixels of the selected codeword, row by row, tagged with their image row and column.
// Blocks are placed in raster order over a square image of blocks_per_side blocks per
// side and the position wraps after the last block. An index at or above codebook_size
// or the store depth gives pixel 0 with bad_index set. A load item emits nothing; an
// index item gives one pixel per cycle while the output is not stalled, set by the
// single read port of the codebook RAM. Each pixel passes the RAM read stage and the
// output register. The front end keeps the block position and classifies items into
// a two-entry command queue, so it goes on taking items until the queue is full while
// the back end expands a block and a finished pixel waits in the output register. The
// codebook store has no reset; reading an entry that was never written returns whatever
// the RAM holds. Configuration is written through the always-ready cfg channel; the user
// must write it only while the block is idle; the block itself does not enforce this.
module vq_block_decoder_unit
	import vqbd_pkg::*;
#(
	parameter int CODEBOOK_DEPTH = 32,
	parameter int BLOCK_DIM = 8,
	parameter int MAX_BLOCKS_PER_SIDE = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// Command transfer from the front end into the queue.
	logic push;
	cmd_t push_cmd;
	logic queue_full;

	// Command transfer from the queue into the back end.
	logic pop;
	cmd_t head;
	logic empty;

	vqbd_front #(
		.CODEBOOK_DEPTH     (CODEBOOK_DEPTH),
		.BLOCK_DIM          (BLOCK_DIM),
		.MAX_BLOCKS_PER_SIDE(MAX_BLOCKS_PER_SIDE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_cmd  (push_cmd),
		.queue_full(queue_full)
	);

	vqbd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (queue_full),
		.pop     (pop),
		.head    (head),
		.empty   (empty)
	);

	vqbd_back #(
		.CODEBOOK_DEPTH(CODEBOOK_DEPTH),
		.BLOCK_DIM     (BLOCK_DIM)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// ===== tb/sv/vq_block_decoder_unit_tb.sv =====
// Self-checking testbench for the vector-quantization block decoder top level.
module vq_block_decoder_unit_tb;
	import vqbd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB_DEPTH = 32;
	localparam int DIM = 8;
	localparam int MAX_SIDE = 64;
	localparam int PIX = DIM * DIM;

	// Cycles the sender waits after the last expected pixel before touching the
	// configuration. Loads leave no pixel behind, so up to a full command queue of
	// them may still be in flight in the back end when the last pixel has left.
	localparam int SETTLE = 16;

	// Length of the single long receiver hold-off that backs up the whole pipe.
	localparam int HOLD_CYCLES = 300;

	// Hard limit on the run. The slowest legal run has well under 10k pixels, each
	// behind the longest random receiver stall, so this leaves a wide margin.
	localparam int unsigned CYCLE_LIMIT = 3_000_000;

	// Random part: one configuration per phase, extremes and plain values mixed.
	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 12;
	localparam int PHASE_CB [NUM_PHASES] = '{32, 256, 1, 0, 511, 17, 200, 31};
	localparam int PHASE_SIDE [NUM_PHASES] = '{64, 3, 1, 2, 127, 5, 0, 4};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	vq_block_decoder_unit #(
		.CODEBOOK_DEPTH(CB_DEPTH),
		.BLOCK_DIM(DIM),
		.MAX_BLOCKS_PER_SIDE(MAX_SIDE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------------
	// Shadow state of the decoder. It is updated at the moment an input transfer
	// is accepted, so the expected pixels are queued in the same order in which
	// the block has to produce them.
	// ------------------------------------------------------------------------
	logic [8:0] cb_size = CODEBOOK_SIZE_RST;
	logic [6:0] side_cfg = BLOCKS_PER_SIDE_RST;
	logic [7:0] codebook_bytes [CB_DEPTH][PIX];
	logic [PIX-1:0] written_mask [CB_DEPTH];
	logic [5:0] blk_row = '0;
	logic [5:0] blk_col = '0;

	out_item_t pending_pixels [$];
	int fault_count = 0;
	int unsigned cycle_count = 0;

	// Set by the sender to ask the receiver for one long hold-off.
	bit hold_req = 1'b0;

	// Applies one accepted item to the shadow state. A load updates the codebook
	// copy; a decode queues the 64 pixels of the block and advances the position.
	function automatic void model_block_pixels(in_item_t it);
		int side;
		bit bad;
		bit last_col;
		bit last_row;
		int base_r;
		int base_c;
		int k;
		out_item_t px;
		if (it.mode == MODE_LOAD) begin
			// Loads outside the store are dropped, never folded onto a valid entry.
			if (int'(it.load_entry) < CB_DEPTH && int'(it.load_element) < PIX) begin
				codebook_bytes[it.load_entry][it.load_element] = it.load_value;
				written_mask[it.load_entry][it.load_element] = 1'b1;
			end
			return;
		end
		bad = !(int'(it.code_index) < int'(cb_size) && int'(it.code_index) < CB_DEPTH);
		// A width of zero behaves as one block, anything wider than the maximum is clipped.
		side = (side_cfg == 0) ? 1 : (int'(side_cfg) > MAX_SIDE) ? MAX_SIDE : int'(side_cfg);
		last_col = (int'(blk_col) + 1) >= side;
		last_row = (int'(blk_row) + 1) >= side;
		base_r = int'(blk_row) * DIM;
		base_c = int'(blk_col) * DIM;
		for (int r = 0; r < DIM; r++) begin
			for (int c = 0; c < DIM; c++) begin
				k = r * DIM + c;
				px.pixel = bad ? 8'd0 : codebook_bytes[it.code_index][k];
				px.pixel_row = 9'(base_r + r);
				px.pixel_col = 9'(base_c + c);
				px.block_end = (k == PIX - 1);
				px.image_end = (k == PIX - 1) && last_col && last_row;
				px.bad_index = bad;
				pending_pixels.push_back(px);
			end
		end
		// A position left beyond a lowered width wraps just like the last block does.
		if (last_col) begin
			blk_col = '0;
			blk_row = last_row ? 6'd0 : blk_row + 6'd1;
		end else begin
			blk_col = blk_col + 6'd1;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Item builders. Fields that the mode ignores carry random noise.
	// ------------------------------------------------------------------------
	function automatic in_item_t load_item(int entry, int element, int value);
		in_item_t it;
		it.mode = MODE_LOAD;
		it.load_entry = entry[7:0];
		it.load_element = element[5:0];
		it.load_value = value[7:0];
		it.code_index = 8'($urandom_range(0, 255));
		return it;
	endfunction

	function automatic in_item_t index_item(int idx);
		in_item_t it;
		it.mode = MODE_DECODE;
		it.load_entry = 8'($urandom_range(0, 255));
		it.load_element = 6'($urandom_range(0, 63));
		it.load_value = 8'($urandom_range(0, 255));
		it.code_index = idx[7:0];
		return it;
	endfunction

	// A codeword whose 64 bytes have all been written; entry 0 always qualifies.
	function automatic int pick_full_entry();
		int full [$];
		for (int e = 0; e < CB_DEPTH; e++) begin
			if (&written_mask[e])
				full.push_back(e);
		end
		return full[$urandom_range(0, full.size() - 1)];
	endfunction

	// A codeword that still has unwritten bytes, or -1 when every one is complete.
	function automatic int pick_open_entry();
		int open [$];
		for (int e = 0; e < CB_DEPTH; e++) begin
			if (!(&written_mask[e]))
				open.push_back(e);
		end
		if (open.size() == 0)
			return -1;
		return open[$urandom_range(0, open.size() - 1)];
	endfunction

	// Sender idle length: mostly none or a few cycles, now and then a long gap.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------------
	// Sender side. An item is offered with in_valid and held unchanged until a
	// rising edge sees in_stall low; at that edge the transfer happens and the
	// shadow state is updated. in_valid is only lowered when a gap follows, so
	// back-to-back items keep it high without a glitch.
	// ------------------------------------------------------------------------
	task automatic push_item(in_item_t it);
		in_data <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		model_block_pixels(it);
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stops offering items and waits until every queued pixel has been seen,
	// then lets trailing loads drain out of the back end.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Register writes happen only on an idle block. The shadow copy follows the
	// write at the edge where the transfer takes place.
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int val);
		wait_drained();
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_CODEBOOK_SIZE)
			cb_size = val[8:0];
		else if (idx == CFG_BLOCKS_PER_SIDE)
			side_cfg = val[6:0];
	endtask

	// ------------------------------------------------------------------------
	// Directed table. A row is either a register write or an item. For some
	// decode rows the last pixel of the block can be read straight off the
	// preloaded codewords and the block position, so it is typed in and takes
	// the place of the predicted one.
	// ------------------------------------------------------------------------
	typedef struct {
		bit is_reg;
		logic [CFG_INDEX_W-1:0] reg_idx;
		int reg_val;
		in_item_t item;
		bit typed;
		out_item_t last_px;
	} stim_row_t;

	stim_row_t directed_rows [$];

	function automatic void add_reg(logic [CFG_INDEX_W-1:0] idx, int val);
		stim_row_t row;
		row.is_reg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		row.item = '0;
		row.typed = 1'b0;
		row.last_px = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_item(in_item_t it);
		stim_row_t row;
		row.is_reg = 1'b0;
		row.reg_idx = '0;
		row.reg_val = 0;
		row.item = it;
		row.typed = 1'b0;
		row.last_px = '0;
		directed_rows.push_back(row);
	endfunction

	// Decode row with a typed last pixel; block_end is always set on it.
	function automatic void add_checked(int idx, int pix, int row_no, int col_no, bit img_end,
			bit bad);
		stim_row_t row;
		row.is_reg = 1'b0;
		row.reg_idx = '0;
		row.reg_val = 0;
		row.item = index_item(idx);
		row.typed = 1'b1;
		row.last_px.pixel = pix[7:0];
		row.last_px.pixel_row = row_no[8:0];
		row.last_px.pixel_col = col_no[8:0];
		row.last_px.block_end = 1'b1;
		row.last_px.image_end = img_end;
		row.last_px.bad_index = bad;
		directed_rows.push_back(row);
	endfunction

	// ------------------------------------------------------------------------
	// Receiver pacing. Outside a hold-off out_stall gets exactly one update per clock:
	// short stalls are common, long ones rare, and quiet stretches let the block run at full
	// rate. On request it holds off for HOLD_CYCLES so the command queue fills
	// and the block has to stall its input while the sender keeps offering.
	// ------------------------------------------------------------------------
	initial begin : sink_pacing
		int stall_left;
		int quiet_left;
		int r;
		stall_left = 0;
		quiet_left = 0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (stall_left == 0 && quiet_left == 0) begin
					r = $urandom_range(0, 99);
					if (r < 10)
						quiet_left = $urandom_range(30, 120);
					else if (r < 29)
						stall_left = $urandom_range(1, 3);
					else if (r < 30)
						stall_left = $urandom_range(10, 40);
				end
				if (quiet_left > 0) begin
					quiet_left--;
					out_stall <= 1'b0;
				end else if (stall_left > 0) begin
					stall_left--;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
				end
				@(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checker. Every pixel transfer is matched against the oldest
	// expected pixel, field by field. Values are sampled at the rising edge,
	// before any update made at that edge takes effect.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : pixel_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected pixel transfer: %p", out_data);
			end else begin
				want = pending_pixels.pop_front();
				if (out_data.pixel !== want.pixel || out_data.pixel_row !== want.pixel_row ||
						out_data.pixel_col !== want.pixel_col ||
						out_data.block_end !== want.block_end ||
						out_data.image_end !== want.image_end ||
						out_data.bad_index !== want.bad_index) begin
					fault_count++;
					if (fault_count <= 10)
						$display("pixel mismatch: expected %p, got %p", want, out_data);
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main stimulus.
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int order [PIX];
		int j;
		int t;
		int r;
		int idx;
		int entry;
		int counted;
		bit steady;
		bit paused;
		in_item_t it;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int e = 0; e < CB_DEPTH; e++) begin
			written_mask[e] = '0;
			for (int k = 0; k < PIX; k++)
				codebook_bytes[e][k] = '0;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Preload three codewords so that decodes never touch unwritten bytes.
		// Codeword 0 counts up from 0, codeword 31 counts down from 255, so the
		// last pixel of either can be read at a glance; codeword 1 is random.
		for (int k = 0; k < PIX; k++) begin
			push_item(load_item(0, k, k));
			idle_gap(pick_gap());
			push_item(load_item(CB_DEPTH - 1, k, 255 - k));
			idle_gap(pick_gap());
			push_item(load_item(1, k, $urandom_range(0, 255)));
			idle_gap(pick_gap());
		end

		// Reset configuration: 32 codewords, 64 blocks per side, position (0,0).
		add_checked(0, 63, 7, 7, 1'b0, 1'b0);
		add_checked(31, 192, 7, 15, 1'b0, 1'b0);
		// First index past the codebook size, and the largest index.
		add_checked(32, 0, 7, 23, 1'b0, 1'b1);
		add_checked(255, 0, 7, 31, 1'b0, 1'b1);
		// Decode with every load field at its maximum; they must be ignored.
		it = index_item(1);
		it.load_entry = 8'hFF;
		it.load_element = 6'h3F;
		it.load_value = 8'hFF;
		add_item(it);
		// Loads with code_index at its maximum, plus both value extremes.
		it = load_item(1, 63, 0);
		it.code_index = 8'hFF;
		add_item(it);
		add_item(load_item(1, 0, 255));
		// Loads outside the store must not alias onto entries 0 and 31.
		add_item(load_item(32, 5, 77));
		add_item(load_item(255, 63, 255));
		add_checked(1, 0, 7, 47, 1'b0, 1'b0);
		add_checked(31, 192, 7, 55, 1'b0, 1'b0);
		// An empty codebook turns every index into an error.
		add_reg(CFG_CODEBOOK_SIZE, 0);
		add_checked(0, 0, 7, 63, 1'b0, 1'b1);
		// A size beyond the store depth still rejects indices past the store.
		add_reg(CFG_CODEBOOK_SIZE, 256);
		add_checked(32, 0, 7, 71, 1'b0, 1'b1);
		add_checked(31, 192, 7, 79, 1'b0, 1'b0);
		// Width lowered mid-image: the column is past the edge, so it wraps at once.
		add_reg(CFG_BLOCKS_PER_SIDE, 1);
		add_checked(31, 192, 7, 87, 1'b1, 1'b0);
		add_checked(0, 63, 7, 7, 1'b1, 1'b0);
		// Zero width acts as one block.
		add_reg(CFG_BLOCKS_PER_SIDE, 0);
		add_checked(31, 192, 7, 7, 1'b1, 1'b0);
		// Width above the maximum is clipped to 64 blocks.
		add_reg(CFG_BLOCKS_PER_SIDE, 127);
		add_checked(0, 63, 7, 7, 1'b0, 1'b0);
		// A 2x2 image walked to its end.
		add_reg(CFG_BLOCKS_PER_SIDE, 2);
		add_checked(0, 63, 7, 15, 1'b0, 1'b0);
		add_checked(0, 63, 15, 7, 1'b0, 1'b0);
		add_checked(31, 192, 15, 15, 1'b1, 1'b0);
		add_reg(CFG_CODEBOOK_SIZE, 511);
		add_checked(255, 0, 7, 7, 1'b0, 1'b1);
		// Single-entry codebook: index 1 is already out of range.
		add_reg(CFG_CODEBOOK_SIZE, 1);
		add_checked(1, 0, 7, 15, 1'b0, 1'b1);

		foreach (directed_rows[n]) begin
			if (directed_rows[n].is_reg) begin
				write_reg(directed_rows[n].reg_idx, directed_rows[n].reg_val);
			end else begin
				push_item(directed_rows[n].item);
				if (directed_rows[n].typed)
					pending_pixels[pending_pixels.size() - 1] = directed_rows[n].last_px;
				idle_gap(pick_gap());
			end
		end

		// Random phases. Most traffic is decodes of complete codewords and loads
		// into the store; some decodes draw any index, and a few loads fall
		// outside the store. Now and then a whole codeword is written in a
		// shuffled order and decoded right away.
		paused = 1'b0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_reg(CFG_CODEBOOK_SIZE, PHASE_CB[p]);
			write_reg(CFG_BLOCKS_PER_SIDE, PHASE_SIDE[p]);
			steady = ($urandom_range(0, 3) == 0);
			counted = 0;

			// Long receiver hold-off with the sender pushing decodes back to back.
			if (p == 1) begin
				hold_req = 1'b1;
				for (int n = 0; n < 16; n++)
					push_item(index_item(pick_full_entry()));
				counted = 16;
			end

			while (counted < PHASE_ITEMS) begin
				// Once, the sender stops mid-phase until the pipe is empty.
				if (p == 2 && !paused && counted >= PHASE_ITEMS / 2) begin
					paused = 1'b1;
					wait_drained();
				end
				r = $urandom_range(0, 99);
				entry = (r < 4) ? pick_open_entry() : -1;
				if (entry >= 0) begin
					for (int k = 0; k < PIX; k++)
						order[k] = k;
					for (int k = PIX - 1; k > 0; k--) begin
						j = $urandom_range(0, k);
						t = order[k];
						order[k] = order[j];
						order[j] = t;
					end
					for (int k = 0; k < PIX; k++) begin
						push_item(load_item(entry, order[k], $urandom_range(0, 255)));
						idle_gap(steady ? 0 : pick_gap());
					end
					push_item(index_item(entry));
					counted += PIX + 1;
				end else if (r < 50) begin
					idx = ($urandom_range(0, 9) < 7) ? pick_full_entry() : $urandom_range(0, 255);
					// A valid index must point at a complete codeword.
					if (idx < int'(cb_size) && idx < CB_DEPTH && !(&written_mask[idx]))
						idx = pick_full_entry();
					push_item(index_item(idx));
					counted++;
				end else if (r < 85) begin
					push_item(load_item($urandom_range(0, CB_DEPTH - 1), $urandom_range(0, 63),
						$urandom_range(0, 255)));
					counted++;
				end else begin
					// Dropped by the block; not counted toward the phase.
					push_item(load_item($urandom_range(CB_DEPTH, 255), $urandom_range(0, 63),
						$urandom_range(0, 255)));
				end
				idle_gap(steady ? 0 : pick_gap());
			end
		end

		wait_drained();
		if (fault_count == 0 && pending_pixels.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
